/* hw/rtl/bfrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrc_pkg: shared types and constants for the buffer fill rate controller
// Field widths, controller states, reciprocal constants for the fixed divides
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bfrc_pkg;

  localparam int CNT_W  = 13;          // slice_count
  localparam int DUR_W  = 16;          // slice_duration_us
  localparam int TGT_W  = 20;          // target_fill_us
  localparam int SPD_W  = 20;          // speed_factor
  localparam int FILL_W = CNT_W + DUR_W;
  localparam int ACC_W  = 32;

  // fill error divider: numerator, divisor, iteration counter widths
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 20;
  localparam int DIV_CW = 6;

  localparam int MAX_SLICES     = 4096;
  localparam int TARGET_RESET   = 40000;

  // 0.005 * acc: |acc| / 200 = (|acc| >> 3) / 25, exact for |acc| <= 2^31
  localparam int                        ACC_SHIFT    = 3;
  localparam int                        ACC_RECIP_W  = 29;
  localparam logic [ACC_RECIP_W-1:0]    ACC_RECIP    = 29'd343597384;  // ceil(2^33 / 25)
  localparam int                        ACC_RECIP_SH = 33;

  // smoothing: x / 5, exact for any 32-bit x
  localparam int                        SMOOTH_RECIP_W  = 32;
  localparam logic [SMOOTH_RECIP_W-1:0] SMOOTH_RECIP    = 32'd3435973837; // ceil(2^34 / 5)
  localparam int                        SMOOTH_RECIP_SH = 34;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_ERR_GO,
    S_ERR_WAIT,
    S_ACC,
    S_ACC_DIV,
    S_SUM,
    S_SUM_DIV,
    S_CLAMP,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic    capture;
    logic    set_one;
    logic    mul;
    logic    prep;
    logic    div_start;
    logic    err_load;
    logic    acc_load;
    logic    acc_div_load;
    logic    sum_load;
    logic    sum_div_load;
    logic    smooth_load;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic special;   // frame mode or empty buffer on the input ports
    logic ovf;       // fill error certain to hit the negative limit
    logic div_done;
  } dp_status_t;

endpackage : bfrc_pkg
`default_nettype wire

/* hw/rtl/buffer_fill_rate_controller_unit.sv */
// In wave mode the time from acceptance to out_valid goes mostly to the bit-serial fill
// error divide, which is skipped when the error is certain to saturate; frame mode or an
// empty buffer goes straight to the output register.
// Throughput: one request at a time; the next is taken the cycle after the result is
// loaded into the output register, which waits while the previous result is held.
// Reset (rst, synchronous): target 40000 us, accumulator 0, speed 1.0.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_fill_rate_controller_unit: PI playback speed from buffer occupancy
// Relative fill error, saturating accumulator, smoothing and clamping to a
// Q4.16 speed factor per swapped buffer.
// ----------------------------------------------------------------------------
module buffer_fill_rate_controller_unit
  import bfrc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [TGT_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CNT_W-1:0] slice_count,
  input  wire logic [DUR_W-1:0] slice_duration_us,
  input  wire logic             frame_mode,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SPD_W-1:0]      speed_factor
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bfrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bfrc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .slice_count       (slice_count),
    .slice_duration_us (slice_duration_us),
    .frame_mode        (frame_mode),
    .cmd               (cmd),
    .status            (status),
    .speed_factor      (speed_factor)
  );

endmodule : buffer_fill_rate_controller_unit
`default_nettype wire

/* hw/rtl/bfrc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrc_div: restoring divider for the fill error
// One quotient bit per cycle. The remainder can be preloaded so that only the
// low quotient bits are worked out when the caller knows the quotient is short.
// ----------------------------------------------------------------------------
module bfrc_div
  import bfrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_DW-1:0] rem_init,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_CW-1:0] iters,
  input  wire logic [DIV_DW-1:0] divisor,
  output logic                   done,
  output logic [DIV_NW-1:0]      quo
);

  logic              busy;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] num_sh;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   trial_sub;
  logic              ge;

  assign trial     = {rem, num_sh[DIV_NW-1]};
  assign ge        = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= rem_init;
      num_sh <= num;
      dvs    <= divisor;
      quo    <= '0;
    end else if (busy) begin
      rem    <= ge ? trial_sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_sh <= {num_sh[DIV_NW-2:0], 1'b0};
      quo    <= {quo[DIV_NW-2:0], ge};
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted mid-division");
  a_busy_src: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy)) |-> $past(start))
    else $error("divider went busy without a start");

endmodule : bfrc_div
`default_nettype wire

/* hw/rtl/bfrc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrc_datapath: fill, error, accumulator and speed arithmetic
// Holds the target register, accumulator, current speed and the output
// register; the fill error goes through bfrc_div, the fixed divides by 200
// and 5 are registered reciprocal multiplies.
// ----------------------------------------------------------------------------
module bfrc_datapath
  import bfrc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [TGT_W-1:0] cfg_wdata,
  input  wire logic [CNT_W-1:0] slice_count,
  input  wire logic [DUR_W-1:0] slice_duration_us,
  input  wire logic             frame_mode,
  input  wire ctrl_cmd_t        cmd,
  output dp_status_t            status,
  output logic [SPD_W-1:0]      speed_factor
);

  localparam int EW     = FRAC_BITS + 6;   // signed error
  localparam int MW     = FRAC_BITS + 5;   // error magnitude
  localparam int CUR_W  = FRAC_BITS + 4;   // speed, up to 10.0
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int SMAX   = 10 * ONE;
  localparam int SMIN   = (ONE + 50) / 100;
  localparam int SUM_W  = ACC_W + 1;
  localparam int AQ_W   = ACC_W - ACC_SHIFT;
  localparam int AP_W   = AQ_W + ACC_RECIP_W;
  localparam int Q200_W = AP_W - ACC_RECIP_SH;
  localparam int SP_W   = DIV_NW + SMOOTH_RECIP_W;
  localparam int Q5_W   = SP_W - SMOOTH_RECIP_SH;

  localparam logic [CUR_W-1:0]  SPD_ONE = CUR_W'(ONE);
  localparam logic [CUR_W-1:0]  SPD_MAX = CUR_W'(SMAX);
  localparam logic [CUR_W-1:0]  SPD_MIN = CUR_W'(SMIN);
  localparam logic [MW-1:0]     ERR_LIM = MW'(16 * ONE);
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_SLICES);

  logic [TGT_W-1:0]  target_r;
  logic [CNT_W-1:0]  count_r;
  logic [DUR_W-1:0]  dur_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] diff_r;
  logic              neg_r;
  logic              ovf_r;
  logic signed [EW-1:0]    err_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [Q200_W-1:0] q200_r;
  logic              sum_neg_r;
  logic [DIV_NW-1:0] sum_mag_r;
  logic [Q5_W-1:0]   q5_r;
  logic [CUR_W-1:0]  res_r;
  logic [CUR_W-1:0]  cur_r;

  logic [TGT_W-1:0]  tgt;
  logic [FILL_W-1:0] tgt_ext;
  logic [FILL_W-1:0] over;
  logic [FILL_W-1:0] under;
  logic              acc_neg;
  logic [ACC_W-1:0]  acc_mag;
  logic [AQ_W-1:0]   acc_q_in;
  logic [AP_W-1:0]   acc_prod;
  logic [SP_W-1:0]   sum_prod;
  logic [MW-1:0]     qerr;
  logic [MW-1:0]     err_mag;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] q200;
  logic signed [SUM_W-1:0] spd_sum;
  logic [SUM_W-1:0]  spd_abs;
  logic [31:0]       res_ext;

  logic              div_done;
  logic [DIV_NW-1:0] div_quo;
  logic [DIV_DW-1:0] div_rem_init;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_CW-1:0] div_iters;
  logic [DIV_DW-1:0] div_divisor;

  // a zero target acts as 1
  assign tgt     = (target_r == '0) ? TGT_W'(1) : target_r;
  assign tgt_ext = FILL_W'(tgt);
  assign over    = fill_r - tgt_ext;
  assign under   = tgt_ext - fill_r;
  assign acc_neg = acc_r[ACC_W-1];
  assign acc_mag = acc_neg ? (~acc_r + ACC_W'(1)) : acc_r;

  assign status.special  = frame_mode || (slice_count == '0);
  assign status.ovf      = ovf_r;
  assign status.div_done = div_done;

  // diff < 32 * target here, so only MW quotient bits remain
  assign div_rem_init = diff_r[TGT_W+4:5];
  assign div_num      = {diff_r[4:0], {(DIV_NW-5){1'b0}}};
  assign div_iters    = DIV_CW'(MW);
  assign div_divisor  = tgt;

  bfrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rem_init (div_rem_init),
    .num      (div_num),
    .iters    (div_iters),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign qerr    = div_quo[MW-1:0];
  assign err_mag = (ovf_r || (neg_r && (qerr > ERR_LIM))) ? ERR_LIM : qerr;

  assign acc_sum = {acc_r[ACC_W-1], acc_r} + {{(SUM_W-EW){err_r[EW-1]}}, err_r};

  // |acc| / 200 by reciprocal; the sign goes back on in the sum
  assign acc_q_in = acc_mag[ACC_W-1:ACC_SHIFT];
  assign acc_prod = AP_W'(acc_q_in) * AP_W'(ACC_RECIP);

  assign q200    = acc_neg ? -$signed(SUM_W'(q200_r)) : $signed(SUM_W'(q200_r));
  assign spd_sum = $signed(SUM_W'(ONE)) + {{(SUM_W-EW){err_r[EW-1]}}, err_r} + q200
                   + $signed(SUM_W'({cur_r, 2'b00}));
  assign spd_abs = spd_sum[SUM_W-1] ? -spd_sum : spd_sum;

  assign sum_prod = SP_W'(sum_mag_r) * SP_W'(SMOOTH_RECIP);

  assign res_ext = 32'(res_r);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_r <= TGT_W'(TARGET_RESET);
      acc_r    <= '0;
      cur_r    <= SPD_ONE;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      if (cmd.acc_load) begin
        if (acc_sum[SUM_W-1] != acc_sum[SUM_W-2]) begin
          acc_r <= acc_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                    : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_r <= acc_sum[ACC_W-1:0];
        end
      end
      if (cmd.out_load) begin
        cur_r <= res_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_r <= (slice_count > CNT_MAX) ? CNT_MAX : slice_count;
      dur_r   <= slice_duration_us;
    end
    if (cmd.mul) begin
      fill_r <= FILL_W'(count_r) * FILL_W'(dur_r);
    end
    if (cmd.prep) begin
      neg_r  <= fill_r > tgt_ext;
      diff_r <= (fill_r > tgt_ext) ? over : under;
      ovf_r  <= (fill_r > tgt_ext) && (over >= FILL_W'({tgt, 5'b00000}));
    end
    if (cmd.err_load) begin
      err_r <= neg_r ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
    end
    if (cmd.acc_div_load) begin
      q200_r <= acc_prod[AP_W-1:ACC_RECIP_SH];
    end
    if (cmd.sum_load) begin
      sum_neg_r <= spd_sum[SUM_W-1];
      sum_mag_r <= spd_abs[DIV_NW-1:0];
    end
    if (cmd.sum_div_load) begin
      q5_r <= sum_prod[SP_W-1:SMOOTH_RECIP_SH];
    end
    if (cmd.set_one) begin
      res_r <= SPD_ONE;
    end else if (cmd.smooth_load) begin
      if (sum_neg_r) begin
        res_r <= SPD_MIN;
      end else if (q5_r > Q5_W'(SMAX)) begin
        res_r <= SPD_MAX;
      end else if (q5_r < Q5_W'(SMIN)) begin
        res_r <= SPD_MIN;
      end else begin
        res_r <= q5_r[CUR_W-1:0];
      end
    end
    if (cmd.out_load) begin
      speed_factor <= res_ext[SPD_W-1:0];
    end
  end

endmodule : bfrc_datapath
`default_nettype wire

/* hw/rtl/bfrc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrc_ctrl: sequencing state machine
// Steps the datapath through fill, error, accumulator and smoothing, and
// owns the request handshakes on both channels.
// ----------------------------------------------------------------------------
module bfrc_ctrl
  import bfrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (status.special) begin
            cmd.set_one = 1'b1;
            state_next  = S_OUT;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_ERR_GO;
      end
      S_ERR_GO: begin
        if (status.ovf) begin
          cmd.err_load = 1'b1;
          state_next   = S_ACC;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_ERR_WAIT;
        end
      end
      S_ERR_WAIT: begin
        if (status.div_done) begin
          cmd.err_load = 1'b1;
          state_next   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_load = 1'b1;
        state_next   = S_ACC_DIV;
      end
      S_ACC_DIV: begin
        cmd.acc_div_load = 1'b1;
        state_next       = S_SUM;
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_SUM_DIV;
      end
      S_SUM_DIV: begin
        cmd.sum_div_load = 1'b1;
        state_next       = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.smooth_load = 1'b1;
        state_next      = S_OUT;
      end
      S_OUT: begin
        // previous result must have left the output register
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load || (out_valid && !out_ready);

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted request did not start work");
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_ERR_WAIT))
    else $error("divider finished outside its wait state");

endmodule : bfrc_ctrl
`default_nettype wire
